/* rtl/cpts_pkg.sv */
// shared types and constants for the counter priority task scheduler
package cpts_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int USED_W     = $clog2(SLOT_COUNT + 1);
    localparam int PRIO_W     = 8;
    localparam int CNT_W      = 9;
    localparam int DEPTH_W    = 4;
    localparam int TICK_W     = 32;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [3:0] {
        OP_TICK  = 4'd0,
        OP_YIELD = 4'd1,
        OP_BLOCK = 4'd2,
        OP_WAKE  = 4'd3,
        OP_SPAWN = 4'd4,
        OP_SETPR = 4'd5,
        OP_EXIT  = 4'd6,
        OP_PDIS  = 4'd7,
        OP_PEN   = 4'd8
    } t_op;

    typedef enum logic [1:0] {
        ST_EMPTY = 2'd0,
        ST_RUN   = 2'd1,
        ST_WAIT  = 2'd2,
        ST_EXIT  = 2'd3
    } t_slot_stat;

    typedef enum logic [1:0] {
        RES_OK     = 2'd0,
        RES_FULL   = 2'd1,
        RES_NOWAKE = 2'd2
    } t_res;

    typedef struct packed {
        t_slot_stat          stat;
        logic [PRIO_W-1:0]   prio;
        logic [CNT_W-1:0]    cnt;
        logic [DEPTH_W-1:0]  depth;
    } t_slot_ent;

    localparam int ENT_W = $bits(t_slot_ent);

endpackage

/* rtl/counter_priority_task_scheduler.sv */
// top level of the counter priority task scheduler
//
//  channel     direction  signals                          contents
//  event in    slave      i_s_tvalid o_s_tready i_s_tdata  op, slot, priority_req
//  result out  master     o_m_tvalid i_m_tready o_m_tdata  current_slot .. tick_count
//  config      write      i_cfg_we i_cfg_wdata             init_priority
//
// one event at a time; the slot table lives in one ram with a registered read
// simple events pass through the exec and done states to the result; a reschedule
// adds a scan of the slots in use and, when all runnable counters are zero,
// a second combined recompute and scan pass
// after reset, and after each config write, slot 0 is rewritten in the ram
// before the next event is taken
// a waiting result does not block the next event; the block only holds its
// finished result while the output register is still occupied
module counter_priority_task_scheduler (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // event transfer: [3:0] op, [7:4] slot, [15:8] priority_req
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [cpts_pkg::IN_TDATA_W-1:0] i_s_tdata,
    // result transfer: [3:0] current_slot, [4] switched, [8:5] new_slot,
    // [10:9] status, [42:11] tick_count, [47:43] zero
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [cpts_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    // init_priority register
    input  logic                           i_cfg_we,
    input  logic [cpts_pkg::PRIO_W-1:0]    i_cfg_wdata
);

    import cpts_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CFG  = 5'b00010,
        S_EXEC = 5'b00100,
        S_SCAN = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state                 r_state, n_state;
    logic [3:0]             r_op, n_op;
    logic [3:0]             r_slot, n_slot;
    logic [PRIO_W-1:0]      r_preq, n_preq;
    logic [SLOT_W-1:0]      r_before, n_before;
    logic [SLOT_W-1:0]      r_run, n_run;
    logic [USED_W-1:0]      r_used, n_used;
    logic [TICK_W-1:0]      r_ticks, n_ticks;
    logic [PRIO_W-1:0]      r_init, n_init;
    logic                   r_pend, n_pend;
    logic                   r_full, n_full;
    logic [USED_W-1:0]      r_idx, n_idx;
    logic [SLOT_W-1:0]      r_cmp, n_cmp;
    logic                   r_dv, n_dv;
    logic                   r_found, n_found;
    logic [CNT_W-1:0]       r_top, n_top;
    logic [SLOT_W-1:0]      r_pick, n_pick;
    logic                   r_recomp, n_recomp;
    logic [SLOT_W-1:0]      r_newslot, n_newslot;
    t_res                   r_res, n_res;
    logic                   r_ovalid, n_ovalid;
    logic [OUT_TDATA_W-1:0] r_odata, n_odata;

    // ram port
    logic                   ram_we;
    logic [SLOT_W-1:0]      ram_waddr;
    t_slot_ent              ram_wdata;
    logic [SLOT_W-1:0]      ram_raddr;
    logic [ENT_W-1:0]       ram_rdata;

    t_slot_ent              ent;
    t_slot_ent              wr_ent;
    logic [CNT_W-1:0]       cnt_v;
    logic                   wake_bad;

    cpts_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign ent        = t_slot_ent'(ram_rdata);
    assign o_s_tready = (r_state == S_IDLE) && !r_pend;
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_slot    = r_slot;
        n_preq    = r_preq;
        n_before  = r_before;
        n_run     = r_run;
        n_used    = r_used;
        n_ticks   = r_ticks;
        n_init    = r_init;
        n_pend    = r_pend;
        n_full    = r_full;
        n_idx     = r_idx;
        n_cmp     = r_cmp;
        n_dv      = r_dv;
        n_found   = r_found;
        n_top     = r_top;
        n_pick    = r_pick;
        n_recomp  = r_recomp;
        n_newslot = r_newslot;
        n_res     = r_res;
        n_ovalid  = r_ovalid;
        n_odata   = r_odata;
        ram_we    = 1'b0;
        ram_waddr = r_run;
        ram_wdata = ent;
        ram_raddr = r_run;
        wr_ent    = ent;
        cnt_v     = ent.cnt;
        wake_bad  = 1'b0;

        // result taken downstream
        if (r_ovalid && i_m_tready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (r_pend) begin
                    // refresh slot 0 from init_priority
                    ram_raddr = '0;
                    n_state   = S_CFG;
                end else if (i_s_tvalid) begin
                    n_op      = i_s_tdata[3:0];
                    n_slot    = i_s_tdata[7:4];
                    n_preq    = i_s_tdata[15:8];
                    n_before  = r_run;
                    n_res     = RES_OK;
                    n_newslot = '0;
                    if (t_op'(i_s_tdata[3:0]) == OP_WAKE) begin
                        ram_raddr = SLOT_W'(i_s_tdata[7:4]);
                    end
                    n_state = S_EXEC;
                end
            end
            S_CFG: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                if (r_full) begin
                    wr_ent.stat  = ST_RUN;
                    wr_ent.depth = '0;
                end
                wr_ent.prio = r_init;
                wr_ent.cnt  = CNT_W'(r_init);
                ram_wdata   = wr_ent;
                n_full      = 1'b0;
                n_pend      = 1'b0;
                n_state     = S_IDLE;
            end
            S_EXEC: begin
                // read data holds the current slot, or the wake target
                n_idx     = '0;
                n_dv      = 1'b0;
                n_found   = 1'b0;
                n_top     = '0;
                n_pick    = '0;
                n_recomp  = 1'b0;
                n_state   = S_DONE;
                case (r_op) inside
                    OP_TICK: begin
                        n_ticks = r_ticks + 1'b1;
                        if (ent.cnt != '0) begin
                            wr_ent.cnt = ent.cnt - 1'b1;
                        end
                        ram_we    = 1'b1;
                        ram_wdata = wr_ent;
                        if (wr_ent.cnt == '0 && ent.depth == '0) begin
                            n_state = S_SCAN;
                        end
                    end
                    OP_YIELD, OP_BLOCK, OP_EXIT: begin
                        wr_ent.cnt = '0;
                        if (r_op == OP_BLOCK) begin
                            wr_ent.stat = ST_WAIT;
                        end else if (r_op == OP_EXIT) begin
                            wr_ent.stat = ST_EXIT;
                        end
                        ram_we    = 1'b1;
                        ram_wdata = wr_ent;
                        n_state   = S_SCAN;
                    end
                    OP_WAKE: begin
                        wake_bad = (32'(r_slot) >= 32'(r_used)) ||
                                   (32'(r_slot) >= SLOT_COUNT) ||
                                   (ent.stat == ST_EMPTY) || (ent.stat == ST_EXIT);
                        if (wake_bad) begin
                            n_res = RES_NOWAKE;
                        end else begin
                            wr_ent.stat = ST_RUN;
                            ram_we      = 1'b1;
                            ram_waddr   = SLOT_W'(r_slot);
                            ram_wdata   = wr_ent;
                        end
                    end
                    OP_SPAWN: begin
                        if (32'(r_used) >= SLOT_COUNT) begin
                            n_res = RES_FULL;
                        end else begin
                            // new slot inherits the running slot's priority
                            wr_ent.stat  = ST_RUN;
                            wr_ent.prio  = ent.prio;
                            wr_ent.cnt   = CNT_W'(ent.prio);
                            wr_ent.depth = '0;
                            ram_we       = 1'b1;
                            ram_waddr    = SLOT_W'(r_used);
                            ram_wdata    = wr_ent;
                            n_newslot    = SLOT_W'(r_used);
                            n_used       = r_used + 1'b1;
                        end
                    end
                    OP_SETPR: begin
                        wr_ent.prio = r_preq;
                        wr_ent.cnt  = CNT_W'(r_preq);
                        ram_we      = 1'b1;
                        ram_wdata   = wr_ent;
                    end
                    OP_PDIS: begin
                        if (ent.depth != '1) begin
                            wr_ent.depth = ent.depth + 1'b1;
                        end
                        ram_we    = 1'b1;
                        ram_wdata = wr_ent;
                    end
                    OP_PEN: begin
                        if (ent.depth != '0) begin
                            wr_ent.depth = ent.depth - 1'b1;
                        end
                        ram_we    = 1'b1;
                        ram_wdata = wr_ent;
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN: begin
                // issue side: one read per cycle over the slots in use
                if (r_idx < r_used) begin
                    ram_raddr = SLOT_W'(r_idx);
                    n_cmp     = SLOT_W'(r_idx);
                    n_idx     = r_idx + 1'b1;
                    n_dv      = 1'b1;
                end else begin
                    n_dv = 1'b0;
                end
                // compare side: entry read last cycle, recomputed on the second pass
                if (r_dv) begin
                    if (r_recomp) begin
                        cnt_v      = {1'b0, ent.cnt[CNT_W-1:1]} + CNT_W'(ent.prio);
                        wr_ent.cnt = cnt_v;
                        ram_we     = 1'b1;
                        ram_waddr  = r_cmp;
                        ram_wdata  = wr_ent;
                    end
                    if (ent.stat == ST_RUN && (!r_found || cnt_v > r_top)) begin
                        n_found = 1'b1;
                        n_top   = cnt_v;
                        n_pick  = r_cmp;
                    end
                end else if (r_idx >= r_used) begin
                    if (!r_recomp && r_found && r_top == '0) begin
                        // all runnable counters spent: recompute and scan again
                        n_idx    = '0;
                        n_found  = 1'b0;
                        n_top    = '0;
                        n_pick   = '0;
                        n_recomp = 1'b1;
                    end else begin
                        n_run   = r_pick;
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = {5'b0, r_ticks, r_res, 4'(r_newslot),
                                (r_run != r_before), 4'(r_run)};
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            n_init = i_cfg_wdata;
            n_pend = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_run    <= '0;
            r_used   <= USED_W'(1);
            r_ticks  <= '0;
            r_init   <= PRIO_W'(1);
            r_pend   <= 1'b1;
            r_full   <= 1'b1;
            r_dv     <= 1'b0;
            r_recomp <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_run    <= n_run;
            r_used   <= n_used;
            r_ticks  <= n_ticks;
            r_init   <= n_init;
            r_pend   <= n_pend;
            r_full   <= n_full;
            r_dv     <= n_dv;
            r_recomp <= n_recomp;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_slot    <= n_slot;
        r_preq    <= n_preq;
        r_before  <= n_before;
        r_idx     <= n_idx;
        r_cmp     <= n_cmp;
        r_found   <= n_found;
        r_top     <= n_top;
        r_pick    <= n_pick;
        r_newslot <= n_newslot;
        r_res     <= n_res;
        r_odata   <= n_odata;
    end

endmodule

/* rtl/cpts_ram.sv */
// generic simple dual port ram with registered read
module cpts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* verif/cpts_dispatch_checker.sv */
// checker for the task scheduler: mirrors the slot table and compares every result transfer
`timescale 1ns / 100ps
module cpts_dispatch_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    // [3:0] op, [7:4] slot, [15:8] priority_req
    input  logic [cpts_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    // [3:0] current_slot, [4] switched, [8:5] new_slot, [10:9] status,
    // [42:11] tick_count, [47:43] zero
    input  logic [cpts_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    input  logic                             i_cfg_we,
    input  logic [cpts_pkg::PRIO_W-1:0]      i_cfg_wdata,
    output int                               o_fail_count,
    output int                               o_pending
);
    import cpts_pkg::*;

    typedef struct {
        logic [SLOT_W-1:0] cur;
        logic              moved;
        logic [SLOT_W-1:0] spawned;
        t_res              res;
        logic [TICK_W-1:0] ticks;
    } t_dispatch;

    // mirrored scheduler state
    t_slot_stat         tbl_stat  [SLOT_COUNT];
    logic [PRIO_W-1:0]  tbl_prio  [SLOT_COUNT];
    logic [CNT_W-1:0]   tbl_cnt   [SLOT_COUNT];
    logic [DEPTH_W-1:0] tbl_depth [SLOT_COUNT];
    int                 used_slots;
    logic [SLOT_W-1:0]  run_slot;
    logic [TICK_W-1:0]  tick_total;
    logic [PRIO_W-1:0]  boot_prio;

    t_dispatch dispatch_q[$];
    t_dispatch want;
    int        mismatches = 0;
    int        backlog = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = backlog;

    // lowest runnable slot with the largest counter; hot is low when that counter is zero
    function automatic logic [SLOT_W-1:0] best_slot(output logic hot);
        int                lead;
        logic [SLOT_W-1:0] pick;
        lead = -1;
        pick = '0;
        for (int i = 0; i < used_slots; i++) begin
            if (tbl_stat[i] == ST_RUN && int'(tbl_cnt[i]) > lead) begin
                lead = int'(tbl_cnt[i]);
                pick = SLOT_W'(i);
            end
        end
        hot = (lead != 0);
        return pick;
    endfunction

    function automatic void reschedule();
        logic              hot;
        logic [SLOT_W-1:0] pick;
        pick = best_slot(hot);
        if (!hot) begin
            // one recompute pass, then the second scan is final
            for (int i = 0; i < used_slots; i++)
                tbl_cnt[i] = (tbl_cnt[i] >> 1) + CNT_W'(tbl_prio[i]);
            pick = best_slot(hot);
        end
        run_slot = pick;
    endfunction

    function automatic t_dispatch run_event(input logic [IN_TDATA_W-1:0] word);
        logic [3:0]        op;
        logic [SLOT_W-1:0] wslot;
        logic [PRIO_W-1:0] req;
        logic [SLOT_W-1:0] was;
        t_dispatch         r;
        op        = word[3:0];
        wslot     = word[7:4];
        req       = word[15:8];
        was       = run_slot;
        r.spawned = '0;
        r.res     = RES_OK;
        case (op)
            OP_TICK: begin
                tick_total++;
                if (tbl_cnt[was] != '0)
                    tbl_cnt[was]--;
                if (tbl_cnt[was] == '0 && tbl_depth[was] == '0)
                    reschedule();
            end
            OP_YIELD: begin
                tbl_cnt[was] = '0;
                reschedule();
            end
            OP_BLOCK: begin
                tbl_stat[was] = ST_WAIT;
                tbl_cnt[was]  = '0;
                reschedule();
            end
            OP_WAKE: begin
                if (int'(wslot) >= used_slots || tbl_stat[wslot] == ST_EMPTY ||
                    tbl_stat[wslot] == ST_EXIT)
                    r.res = RES_NOWAKE;
                else
                    tbl_stat[wslot] = ST_RUN;
            end
            OP_SPAWN: begin
                if (used_slots >= SLOT_COUNT) begin
                    r.res = RES_FULL;
                end else begin
                    r.spawned             = SLOT_W'(used_slots);
                    tbl_stat[used_slots]  = ST_RUN;
                    tbl_prio[used_slots]  = tbl_prio[was];
                    tbl_cnt[used_slots]   = CNT_W'(tbl_prio[was]);
                    tbl_depth[used_slots] = '0;
                    used_slots++;
                end
            end
            OP_SETPR: begin
                tbl_prio[was] = req;
                tbl_cnt[was]  = CNT_W'(req);
            end
            OP_EXIT: begin
                tbl_stat[was] = ST_EXIT;
                tbl_cnt[was]  = '0;
                reschedule();
            end
            OP_PDIS: begin
                if (tbl_depth[was] != '1)
                    tbl_depth[was]++;
            end
            OP_PEN: begin
                if (tbl_depth[was] != '0)
                    tbl_depth[was]--;
            end
            default: ;
        endcase
        r.cur   = run_slot;
        r.moved = (run_slot != was);
        r.ticks = tick_total;
        return r;
    endfunction

    task automatic compare_field(input string what, input longint unsigned want_v,
                                 input longint unsigned got_v);
        if (want_v != got_v) begin
            $display("%0t mismatch on %s: expected %0d actual %0d", $time, what, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                tbl_stat[i]  = ST_EMPTY;
                tbl_prio[i]  = '0;
                tbl_cnt[i]   = '0;
                tbl_depth[i] = '0;
            end
            boot_prio   = 8'd1;
            tbl_stat[0] = ST_RUN;
            tbl_prio[0] = boot_prio;
            tbl_cnt[0]  = CNT_W'(boot_prio);
            used_slots  = 1;
            run_slot    = '0;
            tick_total  = '0;
            dispatch_q.delete();
        end else begin
            // a register write reloads slot 0 straight away
            if (i_cfg_we) begin
                boot_prio   = i_cfg_wdata;
                tbl_prio[0] = boot_prio;
                tbl_cnt[0]  = CNT_W'(boot_prio);
            end
            if (i_s_tvalid && i_s_tready)
                dispatch_q.push_back(run_event(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                if (dispatch_q.size() == 0) begin
                    $display("%0t result transfer with none pending: expected none actual %h",
                             $time, i_m_tdata);
                    mismatches++;
                end else begin
                    want = dispatch_q.pop_front();
                    compare_field("current_slot", want.cur, i_m_tdata[3:0]);
                    compare_field("switched", want.moved, i_m_tdata[4]);
                    compare_field("new_slot", want.spawned, i_m_tdata[8:5]);
                    compare_field("status", want.res, i_m_tdata[10:9]);
                    compare_field("tick_count", want.ticks, i_m_tdata[42:11]);
                    compare_field("padding", 0, i_m_tdata[47:43]);
                end
            end
        end
        backlog = dispatch_q.size();
    end

endmodule

/* verif/tb_counter_priority_task_scheduler.sv */
// testbench top: drives scheduler events, register writes and result back-pressure
`timescale 1ns / 100ps
module tb_counter_priority_task_scheduler;
    import cpts_pkg::*;

    // run limit sized for ~1700 items with both sides stalling
    localparam int RUN_LIMIT = 1_000_000;
    localparam int LONG_HOLD = 300;
    localparam int SETTLE    = 40;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [PRIO_W-1:0]      cfg_wdata = '0;

    int          fail_count;
    int          pending;
    int unsigned cycles      = 0;
    int          spawns_sent = 0;
    bit          hold_go     = 1'b0;   // asks the receiver for one long hold-off
    bit          hold_done   = 1'b0;
    bit          calm        = 1'b0;   // no idling on either side once set

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    counter_priority_task_scheduler dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    cpts_dispatch_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // hard stop in case the block hangs or drops a result
    always @(posedge clk) begin
        cycles = cycles + 1;
        if (cycles == RUN_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: random stall bursts, one long hold-off on request, none when calm
    initial begin
        do @(posedge clk); while (!rst_n);
        forever begin
            if (hold_go && !hold_done) begin
                m_tready  <= 1'b0;
                hold_done  = 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
        end
    end

    // one event transfer, with an optional idle burst in front of it
    task automatic send_event(input logic [3:0] op, input logic [3:0] slot,
                              input logic [7:0] prio);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {prio, slot, op};
        if (op == OP_SPAWN)
            spawns_sent++;
        do @(posedge clk); while (!s_tready);
    endtask

    // mostly small priorities so counters run out and recompute passes happen
    function automatic logic [7:0] pick_prio();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 8'($urandom_range(1, 6));
        else if (r < 95)
            return 8'($urandom_range(1, 255));
        return 8'd0;
    endfunction

    task automatic send_random_op();
        int         r;
        int         live;
        logic [3:0] op;
        logic [3:0] slot;
        r    = $urandom_range(0, 99);
        live = (spawns_sent + 1 < SLOT_COUNT) ? spawns_sent + 1 : SLOT_COUNT;
        slot = 4'($urandom_range(0, 15));
        if (r < 34)      op = OP_TICK;
        else if (r < 44) op = OP_YIELD;
        else if (r < 52) op = OP_BLOCK;
        else if (r < 66) op = OP_WAKE;
        else if (r < 72) op = OP_SPAWN;
        else if (r < 80) op = OP_SETPR;
        else if (r < 81) op = OP_EXIT;
        else if (r < 87) op = OP_PDIS;
        else if (r < 95) op = OP_PEN;
        else             op = 4'($urandom_range(9, 15));
        // wakes mostly aim at slots already handed out
        if (op == OP_WAKE && $urandom_range(0, 4) != 0)
            slot = 4'($urandom_range(0, live - 1));
        send_event(op, slot, pick_prio());
    endtask

    task automatic random_run(input int n);
        int items;
        int r;
        int len;
        items = 0;
        while (items < n) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
                send_random_op();
                items++;
            end else if (r < 97) begin
                // tick run drains the running counter
                len = $urandom_range(2, 30);
                repeat (len)
                    send_event(OP_TICK, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
                items += len;
            end else begin
                // drive the preemption depth into saturation and back to the floor
                repeat (17) send_event(OP_PDIS, 4'($urandom_range(0, 15)), pick_prio());
                repeat (3) send_event(OP_TICK, 4'($urandom_range(0, 15)), pick_prio());
                repeat (17) send_event(OP_PEN, 4'($urandom_range(0, 15)), pick_prio());
                items += 37;
            end
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_boot_prio(input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed events with the reset priority of 1
        send_event(OP_TICK, 4'd0, 8'd0);      // counter hits zero, recompute on one slot
        send_event(4'd15, 4'd15, 8'd255);     // unused op code, all field bits high
        send_event(4'd9, 4'd0, 8'd0);
        send_event(OP_WAKE, 4'd15, 8'd0);     // slot never handed out
        send_event(OP_WAKE, 4'd0, 8'd0);
        send_event(OP_SPAWN, 4'd0, 8'd0);
        send_event(OP_SPAWN, 4'd0, 8'd0);
        send_event(OP_SETPR, 4'd0, 8'd255);
        send_event(OP_SPAWN, 4'd0, 8'd0);     // inherits priority 255
        send_event(OP_PDIS, 4'd0, 8'd0);
        send_event(OP_PDIS, 4'd0, 8'd0);
        send_event(OP_TICK, 4'd0, 8'd0);      // preemption held off
        send_event(OP_SETPR, 4'd0, 8'd0);     // priority zero
        send_event(OP_TICK, 4'd0, 8'd0);      // counter floors at zero, still held
        send_event(OP_PEN, 4'd0, 8'd0);
        send_event(OP_PEN, 4'd0, 8'd0);
        send_event(OP_PEN, 4'd0, 8'd0);       // depth floors at zero
        send_event(OP_YIELD, 4'd0, 8'd0);
        send_event(OP_BLOCK, 4'd0, 8'd0);
        send_event(OP_WAKE, 4'd3, 8'd0);
        send_event(OP_EXIT, 4'd0, 8'd0);
        send_event(OP_WAKE, 4'd1, 8'd0);      // exited slot cannot be woken
        send_event(OP_WAKE, 4'd2, 8'd0);
        send_event(OP_TICK, 4'd0, 8'd0);
        s_tvalid <= 1'b0;

        // random phases, register rewritten while idle between them
        for (int ph = 0; ph < 4; ph++) begin
            wait_drained();
            case (ph)
                0:       write_boot_prio(8'd255);
                1:       write_boot_prio(8'd1);
                default: write_boot_prio(8'($urandom_range(2, 254)));
            endcase
            if (ph == 0)
                hold_go = 1'b1;
            if (ph == 3)
                calm = 1'b1;
            random_run(410);
        end

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* sim.f */
rtl/cpts_pkg.sv
rtl/cpts_ram.sv
rtl/counter_priority_task_scheduler.sv
verif/cpts_dispatch_checker.sv
verif/tb_counter_priority_task_scheduler.sv
